// ----- hdl/pki_pkg.sv -----
// pki_pkg: shared types, codes and constants of the pack index parser
// no dependencies; used by pki_parse, pki_outq and pack_index_parser_unit
`default_nettype none

package pki_pkg;

  typedef enum logic [3:0] {
    PH_MAGIC   = 4'd0,
    PH_VERSION = 4'd1,
    PH_FLAGS   = 4'd2,
    PH_KEYLEN  = 4'd3,
    PH_KEY     = 4'd4,
    PH_COUNT   = 4'd5,
    PH_PATHLEN = 4'd6,
    PH_PATH    = 4'd7,
    PH_OFFSET  = 4'd8,
    PH_SIZE    = 4'd9,
    PH_TAIL    = 4'd10
  } phase_t;

  typedef enum logic [1:0] {
    KIND_ENTRY = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_FAIL  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_MAGIC     = 3'd1,
    ERR_VERSION   = 3'd2,
    ERR_KEY       = 3'd3,
    ERR_HEAD      = 3'd4,
    ERR_PATH      = 3'd5,
    ERR_DATA      = 3'd6,
    ERR_TRUNCATED = 3'd7
  } err_t;

  localparam int unsigned LenWidth = 48;

  localparam logic [31:0] HashBasis = 32'd2166136261;
  localparam logic [31:0] HashPrime = 32'd16777619;
  localparam logic [7:0]  PathSep   = 8'h2F;
  localparam logic [LenWidth-1:0] MinFile = LenWidth'(24);
  localparam logic [31:0] VersionOne = 32'd1;

  // magic byte n sits in bits [8n+7:8n]
  localparam logic [63:0] MagicWord = 64'h4B50_5443_4159_4152;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] entry_number;
    logic [31:0] path_length;
    logic [63:0] data_offset;
    logic [63:0] data_size;
    logic [31:0] keystream_word;
    logic        is_obfuscated;
    err_t        fail_code;
    logic        last_result;
  } result_t;

  function automatic result_t mk_result(kind_t kind, logic [31:0] entry,
                                        logic [31:0] plen, logic [63:0] off,
                                        logic [63:0] size, logic [31:0] ks,
                                        logic obf, err_t err);
    result_t r;
    r.kind           = kind;
    r.entry_number   = entry;
    r.path_length    = plen;
    r.data_offset    = off;
    r.data_size      = size;
    r.keystream_word = ks;
    r.is_obfuscated  = obf;
    r.fail_code      = err;
    r.last_result    = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/pki_parse.sv -----
// pki_parse: byte-at-a-time header and entry table parser, up to two results per item
// depends on pki_pkg
`default_nettype none

module pki_parse #(
  parameter int unsigned POSITION_WIDTH = 48
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_fire,
  input  wire logic [7:0]                     in_byte,
  input  wire logic                           in_last,
  input  wire logic [pki_pkg::LenWidth-1:0]   pack_length,
  output logic                                res0_valid,
  output pki_pkg::result_t                    res0,
  output logic                                res1_valid,
  output pki_pkg::result_t                    res1
);

  localparam int unsigned PW = POSITION_WIDTH;
  localparam int unsigned SW = ((PW > pki_pkg::LenWidth) ? PW : pki_pkg::LenWidth) + 2;

  pki_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]      cnt_r, cnt_nxt;
  logic [63:0]     acc_r, acc_nxt;
  logic [PW-1:0]   pos_r, pos_nxt;
  logic [31:0]     brem_r, brem_nxt;
  logic [31:0]     erem_r, erem_nxt;
  logic [31:0]     ectr_r, ectr_nxt;
  logic [31:0]     plen_r, plen_nxt;
  logic [63:0]     off_r, off_nxt;
  logic [31:0]     run_r, run_nxt;
  logic [31:0]     pfx_r, pfx_nxt;
  logic            obf_r, obf_nxt;

  logic [PW-1:0]   after;
  logic [63:0]     v;
  logic [31:0]     v32;
  logic            field_done;
  logic [7:0]      hash_in;
  logic [31:0]     hash_out;
  logic [33:0]     add;
  logic [SW-1:0]   reach;
  logic            beyond;
  logic [64:0]     data_end;
  logic            data_bad;

  logic            do_begin, begin_in_b;
  logic [31:0]     be_entries;
  logic            ev_a, ev_b, ev_c;
  pki_pkg::kind_t  a_kind, b_kind;
  pki_pkg::err_t   a_err, b_err;
  logic [31:0]     ectr_pre;
  logic            obf_pre;
  pki_pkg::result_t ra, rb, rc;

  assign after      = pos_r + PW'(1);
  assign v          = acc_r | ({56'd0, in_byte} << {cnt_r, 3'b000});
  assign v32        = v[31:0];
  assign field_done = ((phase_r == pki_pkg::PH_OFFSET) || (phase_r == pki_pkg::PH_SIZE))
                      ? (cnt_r == 3'd7) : (cnt_r == 3'd3);

  assign hash_in  = (phase_r == pki_pkg::PH_COUNT) ? pki_pkg::PathSep : in_byte;
  assign hash_out = (run_r ^ {24'd0, hash_in}) * pki_pkg::HashPrime;

  always_comb begin
    unique case (phase_r)
      pki_pkg::PH_KEYLEN:  add = {2'b00, v32} + 34'd4;
      pki_pkg::PH_PATHLEN: add = {2'b00, v32} + 34'd16;
      default:             add = 34'd4;
    endcase
  end

  assign reach    = SW'(after) + SW'(add);
  assign beyond   = reach > SW'(pack_length);
  assign data_end = {1'b0, off_r} + {1'b0, v};
  assign data_bad = data_end > 65'(pack_length);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    pos_nxt   = pos_r;
    brem_nxt  = brem_r;
    erem_nxt  = erem_r;
    ectr_nxt  = ectr_r;
    plen_nxt  = plen_r;
    off_nxt   = off_r;
    run_nxt   = run_r;
    pfx_nxt   = pfx_r;
    obf_nxt   = obf_r;
    ev_a       = 1'b0;
    ev_b       = 1'b0;
    ev_c       = 1'b0;
    a_kind     = pki_pkg::KIND_FAIL;
    b_kind     = pki_pkg::KIND_FAIL;
    a_err      = pki_pkg::ERR_NONE;
    b_err      = pki_pkg::ERR_NONE;
    do_begin   = 1'b0;
    begin_in_b = 1'b0;
    be_entries = erem_r;
    ectr_pre   = ectr_r;
    obf_pre    = obf_r;

    if (in_fire) begin
      pos_nxt = after;
      if (phase_r == pki_pkg::PH_COUNT) begin
        pfx_nxt = hash_out;
      end
      unique case (phase_r)
        pki_pkg::PH_MAGIC: begin
          if (pack_length < pki_pkg::MinFile ||
              in_byte != pki_pkg::MagicWord[{cnt_r, 3'b000} +: 8]) begin
            ev_a      = 1'b1;
            a_err     = pki_pkg::ERR_MAGIC;
            phase_nxt = pki_pkg::PH_TAIL;
          end else if (cnt_r == 3'd7) begin
            cnt_nxt   = 3'd0;
            phase_nxt = pki_pkg::PH_VERSION;
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
        pki_pkg::PH_KEY: begin
          run_nxt  = hash_out;
          brem_nxt = brem_r - 32'd1;
          if (brem_r == 32'd1) begin
            phase_nxt = pki_pkg::PH_COUNT;
          end
        end
        pki_pkg::PH_PATH: begin
          run_nxt  = hash_out;
          brem_nxt = brem_r - 32'd1;
          if (brem_r == 32'd1) begin
            phase_nxt = pki_pkg::PH_OFFSET;
          end
        end
        pki_pkg::PH_TAIL: begin
        end
        default: begin
          if (!field_done) begin
            acc_nxt = v;
            cnt_nxt = cnt_r + 3'd1;
          end else begin
            acc_nxt = 64'd0;
            cnt_nxt = 3'd0;
            unique case (phase_r)
              pki_pkg::PH_VERSION: begin
                if (v32 != pki_pkg::VersionOne) begin
                  ev_a      = 1'b1;
                  a_err     = pki_pkg::ERR_VERSION;
                  phase_nxt = pki_pkg::PH_TAIL;
                end else begin
                  phase_nxt = pki_pkg::PH_FLAGS;
                end
              end
              pki_pkg::PH_FLAGS: begin
                obf_nxt   = v32[0];
                phase_nxt = pki_pkg::PH_KEYLEN;
              end
              pki_pkg::PH_KEYLEN: begin
                if (beyond) begin
                  ev_a      = 1'b1;
                  a_err     = pki_pkg::ERR_KEY;
                  phase_nxt = pki_pkg::PH_TAIL;
                end else if (v32 == 32'd0) begin
                  phase_nxt = pki_pkg::PH_COUNT;
                end else begin
                  brem_nxt  = v32;
                  phase_nxt = pki_pkg::PH_KEY;
                end
              end
              pki_pkg::PH_COUNT: begin
                erem_nxt   = v32;
                ectr_nxt   = 32'd0;
                do_begin   = 1'b1;
                be_entries = v32;
              end
              pki_pkg::PH_PATHLEN: begin
                if (beyond) begin
                  ev_a      = 1'b1;
                  a_err     = pki_pkg::ERR_PATH;
                  phase_nxt = pki_pkg::PH_TAIL;
                end else begin
                  plen_nxt  = v32;
                  brem_nxt  = v32;
                  phase_nxt = (v32 == 32'd0) ? pki_pkg::PH_OFFSET : pki_pkg::PH_PATH;
                end
              end
              pki_pkg::PH_OFFSET: begin
                off_nxt   = v;
                phase_nxt = pki_pkg::PH_SIZE;
              end
              default: begin
                ev_a = 1'b1;
                if (data_bad) begin
                  a_err     = pki_pkg::ERR_DATA;
                  phase_nxt = pki_pkg::PH_TAIL;
                end else begin
                  a_kind     = pki_pkg::KIND_ENTRY;
                  ectr_nxt   = ectr_r + 32'd1;
                  erem_nxt   = erem_r - 32'd1;
                  do_begin   = 1'b1;
                  begin_in_b = 1'b1;
                  be_entries = erem_r - 32'd1;
                end
              end
            endcase
          end
        end
      endcase

      if (do_begin) begin
        if (be_entries == 32'd0) begin
          phase_nxt = pki_pkg::PH_TAIL;
          if (begin_in_b) begin
            ev_b   = 1'b1;
            b_kind = pki_pkg::KIND_DONE;
          end else begin
            ev_a   = 1'b1;
            a_kind = pki_pkg::KIND_DONE;
          end
        end else if (beyond) begin
          phase_nxt = pki_pkg::PH_TAIL;
          if (begin_in_b) begin
            ev_b  = 1'b1;
            b_err = pki_pkg::ERR_HEAD;
          end else begin
            ev_a  = 1'b1;
            a_err = pki_pkg::ERR_HEAD;
          end
        end else begin
          run_nxt   = pfx_r;
          phase_nxt = pki_pkg::PH_PATHLEN;
        end
      end

      ectr_pre = ectr_nxt;
      obf_pre  = obf_nxt;

      if (in_last) begin
        ev_c      = (phase_nxt != pki_pkg::PH_TAIL);
        phase_nxt = pki_pkg::PH_MAGIC;
        cnt_nxt   = 3'd0;
        acc_nxt   = 64'd0;
        pos_nxt   = '0;
        brem_nxt  = 32'd0;
        erem_nxt  = 32'd0;
        ectr_nxt  = 32'd0;
        plen_nxt  = 32'd0;
        off_nxt   = 64'd0;
        run_nxt   = pki_pkg::HashBasis;
        pfx_nxt   = pki_pkg::HashBasis;
        obf_nxt   = 1'b0;
      end
    end
  end

  // result slots: primary, follow-up after an entry, truncation
  always_comb begin
    if (a_kind == pki_pkg::KIND_ENTRY) begin
      ra = pki_pkg::mk_result(a_kind, ectr_r, plen_r, off_r, v, run_r, obf_pre, a_err);
    end else begin
      ra = pki_pkg::mk_result(a_kind, ectr_pre, 32'd0, 64'd0, 64'd0, 32'd0, obf_pre, a_err);
    end
    rb = pki_pkg::mk_result(b_kind, ectr_pre, 32'd0, 64'd0, 64'd0, 32'd0, obf_pre, b_err);
    rc = pki_pkg::mk_result(pki_pkg::KIND_FAIL, ectr_pre, 32'd0, 64'd0, 64'd0, 32'd0,
                            obf_pre, pki_pkg::ERR_TRUNCATED);

    res0_valid = ev_a || ev_c;
    res1_valid = ev_a && (ev_b || ev_c);
    res0 = ev_a ? ra : rc;
    res1 = ev_b ? rb : rc;
    res0.last_result = !res1_valid;
    res1.last_result = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pki_pkg::PH_MAGIC;
      cnt_r   <= 3'd0;
      acc_r   <= 64'd0;
      pos_r   <= '0;
      brem_r  <= 32'd0;
      erem_r  <= 32'd0;
      ectr_r  <= 32'd0;
      plen_r  <= 32'd0;
      off_r   <= 64'd0;
      run_r   <= pki_pkg::HashBasis;
      pfx_r   <= pki_pkg::HashBasis;
      obf_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      pos_r   <= pos_nxt;
      brem_r  <= brem_nxt;
      erem_r  <= erem_nxt;
      ectr_r  <= ectr_nxt;
      plen_r  <= plen_nxt;
      off_r   <= off_nxt;
      run_r   <= run_nxt;
      pfx_r   <= pfx_nxt;
      obf_r   <= obf_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pki_outq.sv -----
// pki_outq: four-entry shifting result queue, two writes and one read per cycle
// depends on pki_pkg
`default_nettype none

module pki_outq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push0,
  input  wire pki_pkg::result_t res0,
  input  wire logic             push1,
  input  wire pki_pkg::result_t res1,
  input  wire logic             pop_ready,
  output logic                  head_valid,
  output pki_pkg::result_t      head,
  output logic                  room
);

  localparam int unsigned Depth = 4;

  pki_pkg::result_t q_r   [Depth];
  pki_pkg::result_t q_nxt [Depth];
  logic [2:0] cnt_r, cnt_nxt;
  logic [2:0] base;
  logic       pop;

  assign head_valid = (cnt_r != 3'd0);
  assign head       = q_r[0];
  assign room       = (cnt_r <= 3'd2);
  assign pop        = head_valid && pop_ready;
  assign base       = cnt_r - {2'b00, pop};

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      q_nxt[i] = q_r[i];
    end
    if (pop) begin
      for (int i = 0; i < Depth - 1; i++) begin
        q_nxt[i] = q_r[i + 1];
      end
    end
    for (int i = 0; i < Depth; i++) begin
      if (push0 && base == 3'(i)) begin
        q_nxt[i] = res0;
      end
      if (push1 && base + 3'd1 == 3'(i)) begin
        q_nxt[i] = res1;
      end
    end
    cnt_nxt = base + {2'b00, push0} + {2'b00, push1};
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Depth; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pack_index_parser_unit.sv -----
// pack_index_parser_unit: top level of the pack file index parser
// depends on pki_pkg, pki_parse and pki_outq
//
//  channel | dir | handshake            | payload
//  in      | in  | in_tvalid/in_tready  | in_tdata pack_byte, in_tlast last_byte
//  out     | out | out_tvalid/out_tready| out_tdata entry fields, out_tuser kind,
//          |     |                      | out_tlast last_result
//  cfg     | in  | cfg_valid/cfg_ready  | cfg_data pack_length
//
// one byte per cycle while in_tready is high; a byte's results enter the queue at the edge
// that takes it, and out_tvalid is high from the cycle after
// in_tready drops only while the four-entry result queue holds three or more items
// cfg_ready is always high; synchronous active-low reset clears state and pack_length
`default_nettype none

module pack_index_parser_unit #(
  parameter int unsigned POSITION_WIDTH = 48
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [7:0]   in_tdata,   // [7:0] pack_byte
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [31:0] entry_number, [63:32] path_length, [127:64] data_offset,
  // [191:128] data_size, [223:192] keystream_word, [224] is_obfuscated,
  // [227:225] fail_code, [231:228] zero
  output logic [231:0]      out_tdata,
  output logic [1:0]        out_tuser,  // [1:0] result_kind
  output logic              out_tlast,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [47:0]  cfg_data    // [47:0] pack_length
);

  logic [pki_pkg::LenWidth-1:0] pack_length_r;
  logic             in_fire;
  logic             res0_valid, res1_valid;
  pki_pkg::result_t res0, res1, head;
  logic             room;

  assign cfg_ready = 1'b1;
  assign in_tready = room;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pack_length_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      pack_length_r <= cfg_data;
    end
  end

  pki_parse #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .pack_length(pack_length_r),
    .res0_valid (res0_valid),
    .res0       (res0),
    .res1_valid (res1_valid),
    .res1       (res1)
  );

  pki_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (res0_valid),
    .res0      (res0),
    .push1     (res1_valid),
    .res1      (res1),
    .pop_ready (out_tready),
    .head_valid(out_tvalid),
    .head      (head),
    .room      (room)
  );

  assign out_tdata = {4'b0000, head.fail_code, head.is_obfuscated, head.keystream_word,
                      head.data_size, head.data_offset, head.path_length, head.entry_number};
  assign out_tuser = head.kind;
  assign out_tlast = head.last_result;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// testbench: self-checking stream test of pack_index_parser_unit on pack file images
// builds images byte by byte, predicts each result in-line and checks the result stream
// depends on pki_pkg and the pack_index_parser_unit rtl

module testbench;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_BYTES = 1400;
  localparam int unsigned BURST_BYTES = 300;
  localparam logic [63:0] PACK_MAGIC = 64'h5241_5941_4354_504B;
  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
  localparam logic [7:0] SLASH = 8'h2F;
  localparam logic [47:0] LEN_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] MIN_PACK = 48'd24;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic [7:0] in_tdata = 8'h00;
  logic in_tlast = 1'b0;
  logic out_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [47:0] cfg_data = 48'd0;
  logic in_tready;
  logic out_tvalid;
  logic [231:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;
  logic cfg_ready;

  pack_index_parser_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // parser state as seen from the byte stream
  logic [47:0] pack_len;
  pki_pkg::phase_t phase;
  logic [3:0]  fcount;
  logic [63:0] acc;
  logic [47:0] fpos;
  logic [31:0] bytes_left;
  logic [31:0] entries_left;
  logic [31:0] entry_idx;
  logic [31:0] held_plen;
  logic [63:0] held_off;
  logic [31:0] run_hash;
  logic [31:0] pre_hash;
  logic        obf;

  pki_pkg::result_t byte_results[$];
  pki_pkg::result_t awaited_results[$];
  logic [7:0] pack_img[$];
  logic [47:0] next_len;

  bit send_idles = 1'b1;
  bit recv_idles = 1'b1;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int bytes_sent = 0;
  int images_sent = 0;
  int entries_seen = 0;
  int done_seen = 0;
  int fail_seen = 0;

  function automatic logic [31:0] fnv_step(logic [31:0] h, logic [7:0] b);
    return (h ^ {24'b0, b}) * FNV_PRIME;
  endfunction

  // true when pos + add runs past the configured length, without wrap
  function automatic bit exceeds(logic [63:0] pos, logic [63:0] add);
    logic [63:0] len;
    len = {16'b0, pack_len};
    if (pos > len) return 1'b1;
    return add > len - pos;
  endfunction

  function automatic void rearm_parser();
    phase = pki_pkg::PH_MAGIC;
    fcount = 4'd0;
    acc = 64'd0;
    fpos = 48'd0;
    bytes_left = 32'd0;
    entries_left = 32'd0;
    entry_idx = 32'd0;
    held_plen = 32'd0;
    held_off = 64'd0;
    run_hash = FNV_BASIS;
    pre_hash = FNV_BASIS;
    obf = 1'b0;
  endfunction

  function automatic void post_result(pki_pkg::kind_t kind, logic [31:0] plen,
                                      logic [63:0] off, logic [63:0] size,
                                      logic [31:0] ks, pki_pkg::err_t err);
    pki_pkg::result_t r;
    r.kind = kind;
    r.entry_number = entry_idx;
    r.path_length = plen;
    r.data_offset = off;
    r.data_size = size;
    r.keystream_word = ks;
    r.is_obfuscated = obf;
    r.fail_code = err;
    r.last_result = 1'b0;
    byte_results.insert(byte_results.size(), r);
  endfunction

  function automatic void fail_parse(pki_pkg::err_t code);
    post_result(pki_pkg::KIND_FAIL, 32'd0, 64'd0, 64'd0, 32'd0, code);
    phase = pki_pkg::PH_TAIL;
  endfunction

  function automatic void start_entry(logic [47:0] pos);
    if (entries_left == 32'd0) begin
      post_result(pki_pkg::KIND_DONE, 32'd0, 64'd0, 64'd0, 32'd0, pki_pkg::ERR_NONE);
      phase = pki_pkg::PH_TAIL;
    end else if (exceeds({16'b0, pos}, 64'd4)) begin
      fail_parse(pki_pkg::ERR_HEAD);
    end else begin
      run_hash = pre_hash;
      phase = pki_pkg::PH_PATHLEN;
    end
  endfunction

  // advance the parser by one accepted byte and queue the results it causes
  function automatic void parse_pack_byte(logic [7:0] b, logic is_last);
    logic [47:0] after;
    logic [3:0] need;
    logic [63:0] v;
    pki_pkg::result_t r;
    after = fpos + 48'd1;
    need = (phase == pki_pkg::PH_OFFSET || phase == pki_pkg::PH_SIZE) ? 4'd8 : 4'd4;
    byte_results.delete();
    case (phase)
      pki_pkg::PH_MAGIC: begin
        if (pack_len < MIN_PACK || b != PACK_MAGIC[8*(7-fcount[2:0]) +: 8]) begin
          fail_parse(pki_pkg::ERR_MAGIC);
        end else begin
          fcount = fcount + 4'd1;
          if (fcount >= 4'd8) begin
            fcount = 4'd0;
            phase = pki_pkg::PH_VERSION;
          end
        end
      end
      pki_pkg::PH_KEY: begin
        run_hash = fnv_step(run_hash, b);
        bytes_left = bytes_left - 32'd1;
        if (bytes_left == 32'd0) begin
          pre_hash = fnv_step(run_hash, SLASH);
          phase = pki_pkg::PH_COUNT;
        end
      end
      pki_pkg::PH_PATH: begin
        run_hash = fnv_step(run_hash, b);
        bytes_left = bytes_left - 32'd1;
        if (bytes_left == 32'd0) phase = pki_pkg::PH_OFFSET;
      end
      pki_pkg::PH_TAIL: ;
      default: begin
        acc = acc | (64'(b) << (8 * fcount));
        fcount = fcount + 4'd1;
        if (fcount >= need) begin
          v = acc;
          acc = 64'd0;
          fcount = 4'd0;
          case (phase)
            pki_pkg::PH_VERSION: begin
              if (v != 64'd1) fail_parse(pki_pkg::ERR_VERSION);
              else phase = pki_pkg::PH_FLAGS;
            end
            pki_pkg::PH_FLAGS: begin
              obf = v[0];
              phase = pki_pkg::PH_KEYLEN;
            end
            pki_pkg::PH_KEYLEN: begin
              if (exceeds({16'b0, after}, v + 64'd4)) begin
                fail_parse(pki_pkg::ERR_KEY);
              end else if (v == 64'd0) begin
                pre_hash = fnv_step(run_hash, SLASH);
                phase = pki_pkg::PH_COUNT;
              end else begin
                bytes_left = v[31:0];
                phase = pki_pkg::PH_KEY;
              end
            end
            pki_pkg::PH_COUNT: begin
              entries_left = v[31:0];
              entry_idx = 32'd0;
              start_entry(after);
            end
            pki_pkg::PH_PATHLEN: begin
              if (exceeds({16'b0, after}, v + 64'd16)) begin
                fail_parse(pki_pkg::ERR_PATH);
              end else begin
                held_plen = v[31:0];
                bytes_left = v[31:0];
                phase = (v == 64'd0) ? pki_pkg::PH_OFFSET : pki_pkg::PH_PATH;
              end
            end
            pki_pkg::PH_OFFSET: begin
              held_off = v;
              phase = pki_pkg::PH_SIZE;
            end
            default: begin
              if (held_off > {16'b0, pack_len} || v > {16'b0, pack_len} - held_off) begin
                fail_parse(pki_pkg::ERR_DATA);
              end else begin
                post_result(pki_pkg::KIND_ENTRY, held_plen, held_off, v, run_hash,
                            pki_pkg::ERR_NONE);
                entry_idx = entry_idx + 32'd1;
                entries_left = entries_left - 32'd1;
                start_entry(after);
              end
            end
          endcase
        end
      end
    endcase
    fpos = after;
    if (is_last) begin
      if (phase != pki_pkg::PH_TAIL) fail_parse(pki_pkg::ERR_TRUNCATED);
      rearm_parser();
    end
    if (byte_results.size() > 0) begin
      r = byte_results.pop_back();
      r.last_result = 1'b1;
      byte_results.insert(byte_results.size(), r);
    end
    foreach (byte_results[i]) awaited_results.insert(awaited_results.size(), byte_results[i]);
  endfunction

  function automatic void put_le(logic [63:0] v, int n);
    for (int i = 0; i < n; i++) pack_img.insert(pack_img.size(), v[8*i +: 8]);
  endfunction

  function automatic logic [63:0] rand_upto(logic [63:0] top);
    case ($urandom_range(0, 4))
      0: return 64'd0;
      1: return top;
      default: return {$urandom, $urandom} % (top + 64'd1);
    endcase
  endfunction

  // fill pack_img with one pack file and next_len with the length to configure
  function automatic void make_pack(int key_len, int n_ent, int max_path, bit noisy);
    int plens [8];
    int total;
    int pick;
    int bad;
    int badpos;
    logic [47:0] len;
    logic [63:0] off;
    logic [63:0] sz;
    logic [7:0] mb;
    total = 24 + key_len;
    for (int i = 0; i < n_ent; i++) begin
      plens[i] = (max_path == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, max_path);
      total += 20 + plens[i];
    end
    total += $urandom_range(0, 6);
    pick = $urandom_range(0, 99);
    if (!noisy || pick < 75) len = 48'(total);
    else if (pick < 85) len = 48'(total + $urandom_range(1, 1000));
    else if (pick < 90) len = LEN_MAX;
    else len = 48'($urandom_range(0, total - 1));
    bad = noisy ? $urandom_range(0, 19) : 0;
    badpos = $urandom_range(0, 7);
    pack_img.delete();
    for (int i = 0; i < 8; i++) begin
      mb = PACK_MAGIC[8*(7-i) +: 8];
      if (bad == 1 && i == badpos) mb = mb ^ 8'($urandom_range(1, 255));
      pack_img.insert(pack_img.size(), mb);
    end
    put_le((bad == 2) ? {32'b0, $urandom} : 64'd1, 4);
    put_le({32'b0, $urandom}, 4);
    put_le((bad == 4) ? {32'b0, $urandom} : 64'(key_len), 4);
    for (int i = 0; i < key_len; i++) pack_img.insert(pack_img.size(), 8'($urandom));
    put_le((bad == 3) ? 64'(n_ent + $urandom_range(1, 2)) : 64'(n_ent), 4);
    for (int i = 0; i < n_ent; i++) begin
      put_le((bad == 5 && i == n_ent - 1) ? {32'b0, $urandom} : 64'(plens[i]), 4);
      for (int j = 0; j < plens[i]; j++) pack_img.insert(pack_img.size(), 8'($urandom));
      off = rand_upto({16'b0, len});
      sz = rand_upto({16'b0, len} - off);
      if (bad == 6 && i == n_ent - 1) begin
        if ($urandom_range(0, 1) == 1) begin
          sz = {16'b0, len} - off + 64'd1 + 64'($urandom_range(0, 7));
        end else begin
          off = {$urandom, $urandom};
        end
      end
      put_le(off, 8);
      put_le(sz, 8);
    end
    while (pack_img.size() < total) pack_img.insert(pack_img.size(), 8'($urandom));
    next_len = len;
  endfunction

  task automatic send_byte(logic [7:0] b, logic is_last);
    while (send_idles && $urandom_range(0, 99) < 17) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= is_last;
    do @(posedge clk); while (!in_tready);
    parse_pack_byte(b, is_last);
    bytes_sent++;
  endtask

  task automatic send_image(int upto);
    for (int i = 0; i < upto; i++) send_byte(pack_img[i], i == upto - 1);
    images_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_pack_length(logic [47:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    pack_len = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // too short a length fails on the first magic byte; trailing bytes are ignored
  task automatic test_short_file();
    write_pack_length(48'd0);
    send_byte(8'h52, 1'b1);
    wait_idle();
    write_pack_length(MIN_PACK - 48'd1);
    send_byte(8'h52, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    wait_idle();
  endtask

  task automatic test_early_end();
    write_pack_length(LEN_MAX);
    send_byte(8'h52, 1'b0);
    send_byte(8'h41, 1'b1);
    wait_idle();
  endtask

  // smallest legal file: empty key, no entries, done on the last count byte
  task automatic test_empty_table();
    pack_img.delete();
    put_le(64'(PACK_MAGIC[63:56]), 1);
    for (int i = 1; i < 8; i++) put_le(64'(PACK_MAGIC[8*(7-i) +: 8]), 1);
    put_le(64'd1, 4);
    put_le(64'd1, 4);
    put_le(64'd0, 4);
    put_le(64'd0, 4);
    wait_idle();
    write_pack_length(MIN_PACK);
    send_image(pack_img.size());
    wait_idle();
  endtask

  task automatic test_random_packs(int target);
    int first;
    int cut;
    first = bytes_sent;
    while (bytes_sent - first < target) begin
      if ($urandom_range(0, 99) < 4) begin
        pack_img.delete();
        repeat ($urandom_range(1, 30)) pack_img.insert(pack_img.size(), 8'($urandom));
        next_len = 48'($urandom_range(0, 100));
      end else begin
        make_pack(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6),
                  $urandom_range(0, 4), 6, 1'b1);
      end
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, pack_img.size()) : pack_img.size();
      wait_idle();
      write_pack_length(next_len);
      send_image(cut);
    end
    wait_idle();
  endtask

  task automatic test_back_to_back();
    send_idles = 1'b0;
    recv_idles = 1'b0;
    test_random_packs(BURST_BYTES);
    send_idles = 1'b1;
    recv_idles = 1'b1;
  endtask

  // receiver stalls long enough for the result queue to fill and block the input
  task automatic test_receiver_hold();
    make_pack(3, 8, 0, 1'b0);
    wait_idle();
    write_pack_length(next_len);
    hold_requests++;
    send_image(pack_img.size());
    wait_idle();
  endtask

  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !recv_idles || ($urandom_range(0, 99) >= 17);
    end
  end

  task automatic show_result(string tag, pki_pkg::result_t r);
    $display("  %s kind %0d entry %0d plen %0d off %h size %h", tag, r.kind,
             r.entry_number, r.path_length, r.data_offset, r.data_size);
    $display("  %s hash %h obf %0d err %0d last %0d", tag, r.keystream_word,
             r.is_obfuscated, r.fail_code, r.last_result);
  endtask

  always @(posedge clk) begin : check_results
    pki_pkg::result_t want;
    pki_pkg::result_t got;
    string bad;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = pki_pkg::kind_t'(out_tuser);
      got.entry_number = out_tdata[31:0];
      got.path_length = out_tdata[63:32];
      got.data_offset = out_tdata[127:64];
      got.data_size = out_tdata[191:128];
      got.keystream_word = out_tdata[223:192];
      got.is_obfuscated = out_tdata[224];
      got.fail_code = pki_pkg::err_t'(out_tdata[227:225]);
      got.last_result = out_tlast;
      bad = "";
      if (awaited_results.size() == 0) begin
        want = '0;
        bad = " no result awaited";
      end else begin
        want = awaited_results.pop_front();
        if (out_tuser !== want.kind) bad = {bad, " kind"};
        if (out_tdata[31:0] !== want.entry_number) bad = {bad, " entry"};
        if (out_tdata[63:32] !== want.path_length) bad = {bad, " path_length"};
        if (out_tdata[127:64] !== want.data_offset) bad = {bad, " offset"};
        if (out_tdata[191:128] !== want.data_size) bad = {bad, " size"};
        if (out_tdata[223:192] !== want.keystream_word) bad = {bad, " hash"};
        if (out_tdata[224] !== want.is_obfuscated) bad = {bad, " obfuscated"};
        if (out_tdata[227:225] !== want.fail_code) bad = {bad, " error"};
        if (out_tdata[231:228] !== 4'b0) bad = {bad, " pad"};
        if (out_tlast !== want.last_result) bad = {bad, " last"};
      end
      if (bad != "") begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch at %0t:%s", $time, bad);
          show_result("expected", want);
          show_result("actual  ", got);
        end
      end
      if (out_tuser == pki_pkg::KIND_ENTRY) entries_seen++;
      else if (out_tuser == pki_pkg::KIND_DONE) done_seen++;
      else fail_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycle_count,
               awaited_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    pack_len = 48'd0;
    rearm_parser();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_file();
    test_early_end();
    test_empty_table();
    test_random_packs(RANDOM_BYTES);
    test_back_to_back();
    test_receiver_hold();
    wait_idle();
    $display("sent %0d bytes in %0d pack images plus short directed streams", bytes_sent,
             images_sent);
    $display("checked %0d entries, %0d done and %0d failed results, %0d mismatches",
             entries_seen, done_seen, fail_seen, mismatches);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- pack_index_parser_unit.f -----
hdl/pki_pkg.sv
hdl/pki_parse.sv
hdl/pki_outq.sv
hdl/pack_index_parser_unit.sv
tb/testbench.sv
